// ===== sv/rudp_rx_pkg.sv =====
// ----------------------------------------------------------------------------
// rudp_rx_pkg
// Shared types and constants of the reliable datagram receive reorder block.
// ----------------------------------------------------------------------------
package rudp_rx_pkg;

  localparam int WINDOW_DEF    = 32;
  localparam int HDR_SIZE_DEF  = 16;
  localparam int MAX_DGRAM_DEF = 1024;

  localparam int TAG_WIDTH = 16;
  localparam int SEQ_WIDTH = 32;
  localparam int LEN_WIDTH = 11;
  localparam int KIND_WIDTH = 3;
  // Wide enough for any packet length limit and for payload length plus header.
  localparam int CMP_WIDTH = 17;

  typedef enum logic [KIND_WIDTH-1:0] {
    PK_DATA   = 3'd0,
    PK_ACK    = 3'd1,
    PK_SYN    = 3'd2,
    PK_SYNACK = 3'd3,
    PK_NAT    = 3'd4,
    PK_RDV    = 3'd5
  } pkt_kind_t;

  typedef enum logic [KIND_WIDTH-1:0] {
    RES_ACK_REPLY    = 3'd0,
    RES_SYNACK_REPLY = 3'd1,
    RES_NAT_REPLY    = 3'd2,
    RES_DELIVER      = 3'd3,
    RES_SYNACK_SEEN  = 3'd4,
    RES_ACK_RCVD     = 3'd5,
    RES_RDV_SEEN     = 3'd6
  } res_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT,
    ST_READ,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic accept;
    logic check;
    logic emit;
    logic deliver;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic drop;
    logic deliver;
    logic next_valid;
  } dp_stat_t;

endpackage

// ===== sv/rudp_rx_if.sv =====
// ----------------------------------------------------------------------------
// rudp_rx_if
// Valid/ready channels for received datagram headers and for results.
// ----------------------------------------------------------------------------
interface rudp_rx_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [rudp_rx_pkg::KIND_WIDTH-1:0]   pkt_kind;
  logic [rudp_rx_pkg::SEQ_WIDTH-1:0]    pkt_stream;
  logic [rudp_rx_pkg::SEQ_WIDTH-1:0]    pkt_seq;
  logic [rudp_rx_pkg::SEQ_WIDTH-1:0]    pkt_acknum;
  logic [rudp_rx_pkg::LEN_WIDTH-1:0]    datagram_len;
  logic [rudp_rx_pkg::LEN_WIDTH-1:0]    payload_len;
  logic [rudp_rx_pkg::TAG_WIDTH-1:0]    payload_tag;

  modport source (
    output valid, pkt_kind, pkt_stream, pkt_seq, pkt_acknum,
           datagram_len, payload_len, payload_tag,
    input  ready
  );
  modport sink (
    input  valid, pkt_kind, pkt_stream, pkt_seq, pkt_acknum,
           datagram_len, payload_len, payload_tag,
    output ready
  );
endinterface

interface rudp_rx_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [rudp_rx_pkg::KIND_WIDTH-1:0]   result_kind;
  logic [rudp_rx_pkg::SEQ_WIDTH-1:0]    out_seq;
  logic [rudp_rx_pkg::SEQ_WIDTH-1:0]    out_acknum;
  logic [rudp_rx_pkg::TAG_WIDTH-1:0]    out_tag;
  logic                                 last;

  modport source (
    output valid, result_kind, out_seq, out_acknum, out_tag, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, out_seq, out_acknum, out_tag, last,
    output ready
  );
endinterface

// ===== sv/rudp_rx_ram.sv =====
// ----------------------------------------------------------------------------
// rudp_rx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rudp_rx_ram #(
  parameter int WIDTH = rudp_rx_pkg::TAG_WIDTH,
  parameter int DEPTH = rudp_rx_pkg::WINDOW_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/rudp_rx_ctrl.sv =====
// ----------------------------------------------------------------------------
// rudp_rx_ctrl
// Sequencer: accept, check, emit the first result unless dropped, then walk in-order slots.
// ----------------------------------------------------------------------------
module rudp_rx_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output rudp_rx_pkg::dp_cmd_t  cmd,
  input  rudp_rx_pkg::dp_stat_t stat
);

  rudp_rx_pkg::state_t state_r;
  rudp_rx_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rudp_rx_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rudp_rx_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = rudp_rx_pkg::ST_CHECK;
        end
      end
      rudp_rx_pkg::ST_CHECK: begin
        state_nxt = stat.drop ? rudp_rx_pkg::ST_IDLE : rudp_rx_pkg::ST_EMIT;
      end
      rudp_rx_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          state_nxt = stat.deliver ? rudp_rx_pkg::ST_READ : rudp_rx_pkg::ST_IDLE;
        end
      end
      rudp_rx_pkg::ST_READ: begin
        state_nxt = rudp_rx_pkg::ST_DELIVER;
      end
      rudp_rx_pkg::ST_DELIVER: begin
        if (stat.out_free) begin
          state_nxt = stat.next_valid ? rudp_rx_pkg::ST_READ : rudp_rx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rudp_rx_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      rudp_rx_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      rudp_rx_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
      end
      rudp_rx_pkg::ST_EMIT: begin
        cmd.emit = stat.out_free;
      end
      rudp_rx_pkg::ST_READ: begin
      end
      rudp_rx_pkg::ST_DELIVER: begin
        cmd.deliver = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/rudp_rx_dp.sv =====
// ----------------------------------------------------------------------------
// rudp_rx_dp
// Datapath: header checks, window slot store, expected sequence and output.
// ----------------------------------------------------------------------------
module rudp_rx_dp #(
  parameter int WINDOW    = rudp_rx_pkg::WINDOW_DEF,
  parameter int HDR_SIZE  = rudp_rx_pkg::HDR_SIZE_DEF,
  parameter int MAX_DGRAM = rudp_rx_pkg::MAX_DGRAM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rudp_rx_pkg::SEQ_WIDTH-1:0]   cfg_wdata,
  input  logic [rudp_rx_pkg::KIND_WIDTH-1:0]  in_pkt_kind,
  input  logic [rudp_rx_pkg::SEQ_WIDTH-1:0]   in_pkt_stream,
  input  logic [rudp_rx_pkg::SEQ_WIDTH-1:0]   in_pkt_seq,
  input  logic [rudp_rx_pkg::SEQ_WIDTH-1:0]   in_pkt_acknum,
  input  logic [rudp_rx_pkg::LEN_WIDTH-1:0]   in_datagram_len,
  input  logic [rudp_rx_pkg::LEN_WIDTH-1:0]   in_payload_len,
  input  logic [rudp_rx_pkg::TAG_WIDTH-1:0]   in_payload_tag,
  input  rudp_rx_pkg::dp_cmd_t                cmd,
  output rudp_rx_pkg::dp_stat_t               stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [rudp_rx_pkg::KIND_WIDTH-1:0]  out_result_kind,
  output logic [rudp_rx_pkg::SEQ_WIDTH-1:0]   out_seq,
  output logic [rudp_rx_pkg::SEQ_WIDTH-1:0]   out_acknum,
  output logic [rudp_rx_pkg::TAG_WIDTH-1:0]   out_tag,
  output logic                                out_last
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SW    = rudp_rx_pkg::SEQ_WIDTH;
  localparam int CW    = rudp_rx_pkg::CMP_WIDTH;
  localparam int TW    = rudp_rx_pkg::TAG_WIDTH;

  localparam logic [IDX_W:0]   WIN_EXT  = (IDX_W + 1)'(WINDOW);
  localparam logic [IDX_W-1:0] WIN_LAST = IDX_W'(WINDOW - 1);
  localparam logic [SW-1:0]    WIN_SEQ  = SW'(WINDOW);
  localparam logic [CW-1:0]    HDR_LEN  = CW'(HDR_SIZE);
  localparam logic [CW-1:0]    PKT_LEN  = CW'(MAX_DGRAM);

  typedef struct packed {
    rudp_rx_pkg::res_kind_t rkind;
    logic [SW-1:0]          seq;
    logic [SW-1:0]          acknum;
    logic                   store;
    logic                   deliver;
  } dec_t;

  // Configuration and captured header.
  logic [SW-1:0]                       own_stream_r;
  logic [rudp_rx_pkg::KIND_WIDTH-1:0]  kind_r;
  logic [SW-1:0]                       stream_r;
  logic [SW-1:0]                       seq_r;
  logic [SW-1:0]                       acknum_r;
  logic [rudp_rx_pkg::LEN_WIDTH-1:0]   dlen_r;
  logic [rudp_rx_pkg::LEN_WIDTH-1:0]   plen_r;
  logic [TW-1:0]                       tag_r;

  // Reorder state.
  logic [SW-1:0]     exp_r;
  logic [IDX_W-1:0]  exp_idx_r;
  logic [WINDOW-1:0] slot_valid_r;

  // Decision of the check cycle.
  dec_t              dec_r;
  dec_t              dec_nxt;
  logic              drop_nxt;
  logic [IDX_W-1:0]  seq_idx_r;

  // Output register.
  logic                   out_valid_r;
  rudp_rx_pkg::res_kind_t out_kind_r;
  logic [SW-1:0]          out_seq_r;
  logic [SW-1:0]          out_ack_r;
  logic [TW-1:0]          out_tag_r;
  logic                   out_last_r;

  logic [CW-1:0]    dlen_x;
  logic [CW-1:0]    need_len;
  logic             len_bad;
  logic [SW-1:0]    diff;
  logic             seq_ge;
  logic             in_win;
  logic [IDX_W:0]   idx_sum;
  logic [IDX_W:0]   idx_fix;
  logic [IDX_W-1:0] seq_idx;
  logic             held;
  logic [IDX_W-1:0] next_idx;
  logic             next_valid;
  logic             out_free;
  logic [TW-1:0]    ram_rdata;

  assign out_free = !out_valid_r || out_ready;

  // Header checks and slot index of the data sequence number.
  always_comb begin
    dlen_x   = CW'(dlen_r);
    need_len = CW'(plen_r) + HDR_LEN;
    len_bad  = (dlen_x < HDR_LEN) || (dlen_x > PKT_LEN) || (dlen_x != need_len);
    diff     = seq_r - exp_r;
    seq_ge   = (seq_r >= exp_r);
    in_win   = (diff < WIN_SEQ);
    // Inside the window the offset is below WINDOW, so one conditional
    // subtract reduces the slot index.
    idx_sum  = {1'b0, exp_idx_r} + {1'b0, diff[IDX_W-1:0]};
    idx_fix  = idx_sum - WIN_EXT;
    seq_idx  = (idx_sum >= WIN_EXT) ? idx_fix[IDX_W-1:0] : idx_sum[IDX_W-1:0];
    held     = slot_valid_r[seq_idx];
  end

  always_comb begin
    dec_nxt         = '0;
    dec_nxt.rkind   = rudp_rx_pkg::RES_ACK_REPLY;
    drop_nxt        = 1'b1;
    priority if (len_bad) begin
      drop_nxt = 1'b1;
    end else if (kind_r == rudp_rx_pkg::PK_RDV) begin
      drop_nxt      = 1'b0;
      dec_nxt.rkind = rudp_rx_pkg::RES_RDV_SEEN;
    end else if (stream_r != own_stream_r) begin
      drop_nxt = 1'b1;
    end else if (kind_r == rudp_rx_pkg::PK_SYN) begin
      drop_nxt      = 1'b0;
      dec_nxt.rkind = rudp_rx_pkg::RES_SYNACK_REPLY;
    end else if (kind_r == rudp_rx_pkg::PK_SYNACK) begin
      drop_nxt      = 1'b0;
      dec_nxt.rkind = rudp_rx_pkg::RES_SYNACK_SEEN;
    end else if (kind_r == rudp_rx_pkg::PK_NAT) begin
      drop_nxt      = 1'b0;
      dec_nxt.rkind = rudp_rx_pkg::RES_NAT_REPLY;
    end else if (kind_r == rudp_rx_pkg::PK_ACK) begin
      drop_nxt       = 1'b0;
      dec_nxt.rkind  = rudp_rx_pkg::RES_ACK_RCVD;
      dec_nxt.acknum = acknum_r;
    end else if (kind_r == rudp_rx_pkg::PK_DATA) begin
      drop_nxt        = seq_ge && !in_win;
      dec_nxt.rkind   = rudp_rx_pkg::RES_ACK_REPLY;
      dec_nxt.seq     = seq_r;
      dec_nxt.store   = seq_ge && !held;
      // The expected slot is never held between items, so release starts
      // only when this datagram fills it.
      dec_nxt.deliver = seq_ge && !held && (diff == '0);
    end else begin
      drop_nxt = 1'b1;
    end
  end

  // Slot after the expected one, and whether it is held once this one is freed.
  always_comb begin
    if (exp_r == '1 || exp_idx_r == WIN_LAST) begin
      next_idx = '0;
    end else begin
      next_idx = exp_idx_r + 1'b1;
    end
    next_valid = slot_valid_r[next_idx] && (next_idx != exp_idx_r);
  end

  always_comb begin
    stat            = '0;
    stat.out_free   = out_free;
    stat.drop       = drop_nxt;
    stat.deliver    = dec_r.deliver;
    stat.next_valid = next_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_stream_r <= '0;
    end else if (cfg_we) begin
      own_stream_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r   <= in_pkt_kind;
      stream_r <= in_pkt_stream;
      seq_r    <= in_pkt_seq;
      acknum_r <= in_pkt_acknum;
      dlen_r   <= in_datagram_len;
      plen_r   <= in_payload_len;
      tag_r    <= in_payload_tag;
    end
    if (cmd.check) begin
      dec_r     <= dec_nxt;
      seq_idx_r <= seq_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r        <= '0;
      exp_idx_r    <= '0;
      slot_valid_r <= '0;
    end else begin
      if (cmd.emit && dec_r.store) begin
        slot_valid_r[seq_idx_r] <= 1'b1;
      end
      if (cmd.deliver) begin
        slot_valid_r[exp_idx_r] <= 1'b0;
        exp_r                   <= exp_r + 1'b1;
        exp_idx_r               <= next_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.deliver) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= dec_r.rkind;
      out_seq_r  <= dec_r.seq;
      out_ack_r  <= dec_r.acknum;
      out_tag_r  <= '0;
      out_last_r <= !dec_r.deliver;
    end else if (cmd.deliver) begin
      out_kind_r <= rudp_rx_pkg::RES_DELIVER;
      out_seq_r  <= exp_r;
      out_ack_r  <= '0;
      out_tag_r  <= ram_rdata;
      out_last_r <= !next_valid;
    end
  end

  rudp_rx_ram #(
    .WIDTH (TW),
    .DEPTH (WINDOW)
  ) u_tag_ram (
    .clk   (clk),
    .we    (cmd.emit && dec_r.store),
    .waddr (seq_idx_r),
    .wdata (tag_r),
    .raddr (exp_idx_r),
    .rdata (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_seq         = out_seq_r;
  assign out_acknum      = out_ack_r;
  assign out_tag         = out_tag_r;
  assign out_last        = out_last_r;

endmodule

// ===== sv/reliable_udp_receive_reorder_top.sv =====
// ----------------------------------------------------------------------------
// reliable_udp_receive_reorder_top
// Receive side of a reliable datagram endpoint with a reorder window.
// ----------------------------------------------------------------------------
// Each input transaction carries one received datagram header. Every item
// is captured, then passes the header check, then hands its first result
// to the output register; an item that is dropped ends after the check. A
// data datagram that completes a run of in-order sequence numbers then
// releases each held payload tag in turn; each release reads the tag store
// (a RAM with registered read) at the expected slot before the result can
// be formed, and a data item releases at most WINDOW tags. Backpressure on
// the result channel stalls the first result and each release. The result
// channel has its own output register, so the next header is accepted
// while the last result of the previous item still waits to be taken. The
// slot valid bits are flip-flops cleared by reset, so the block is ready
// right after reset with no clearing pass.
//
// Datagrams with a bad length are dropped. A rendezvous datagram raises an
// event for any stream; other datagrams whose stream differs from own_stream
// are dropped. Data is acked first, then dropped as a duplicate if it is
// older than the expected number or its slot is already held; data at or
// beyond the end of the window is dropped without an ack. The final result
// of every item carries last. The own_stream register is written through
// cfg_we and cfg_wdata and should only be changed while the block is idle.
module reliable_udp_receive_reorder_top #(
  parameter int WINDOW    = rudp_rx_pkg::WINDOW_DEF,
  parameter int HDR_SIZE  = rudp_rx_pkg::HDR_SIZE_DEF,
  parameter int MAX_DGRAM = rudp_rx_pkg::MAX_DGRAM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rudp_rx_pkg::SEQ_WIDTH-1:0] cfg_wdata,
  rudp_rx_in_if.sink                        in_ch,
  rudp_rx_out_if.source                     out_ch
);

  // Command and status between the sequencer and the datapath.
  rudp_rx_pkg::dp_cmd_t  cmd;
  rudp_rx_pkg::dp_stat_t stat;
  logic                  in_ready;

  rudp_rx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  rudp_rx_dp #(
    .WINDOW    (WINDOW),
    .HDR_SIZE  (HDR_SIZE),
    .MAX_DGRAM (MAX_DGRAM)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_pkt_kind     (in_ch.pkt_kind),
    .in_pkt_stream   (in_ch.pkt_stream),
    .in_pkt_seq      (in_ch.pkt_seq),
    .in_pkt_acknum   (in_ch.pkt_acknum),
    .in_datagram_len (in_ch.datagram_len),
    .in_payload_len  (in_ch.payload_len),
    .in_payload_tag  (in_ch.payload_tag),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_result_kind (out_ch.result_kind),
    .out_seq         (out_ch.out_seq),
    .out_acknum      (out_ch.out_acknum),
    .out_tag         (out_ch.out_tag),
    .out_last        (out_ch.last)
  );

  // A header transaction is taken only while the sequencer is idle.
  assign in_ch.ready = in_ready;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the datagram receive reorder block.
// ----------------------------------------------------------------------------
// Received datagram headers are queued by a stimulus process and driven by a
// clocked driver with random gaps. A clocked monitor takes results under
// random backpressure. A predictor tracks the stream register, the expected
// sequence number and the reorder slots. It is updated on every accepted
// input transaction and queues the results that transaction must cause. The
// monitor compares each result, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int WINDOW       = rudp_rx_pkg::WINDOW_DEF;
  localparam int HDR_SIZE     = rudp_rx_pkg::HDR_SIZE_DEF;
  localparam int MAX_DGRAM    = rudp_rx_pkg::MAX_DGRAM_DEF;
  localparam int LEN_WIDTH    = rudp_rx_pkg::LEN_WIDTH;
  localparam int KIND_WIDTH   = rudp_rx_pkg::KIND_WIDTH;
  localparam int SEQ_WIDTH    = rudp_rx_pkg::SEQ_WIDTH;
  localparam int TAG_WIDTH    = rudp_rx_pkg::TAG_WIDTH;
  localparam int RESET_CYCLES = 12;
  // A dropped header leaves the block after its check state; this margin
  // covers it before the stream register is touched again.
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int LEN_ALL_ONES = (1 << LEN_WIDTH) - 1;

  // Header kinds that the package leaves unassigned; the block ignores them.
  localparam logic [KIND_WIDTH-1:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [KIND_WIDTH-1:0] KIND_UNUSED_HI = 3'd7;

  typedef logic [SEQ_WIDTH-1:0] seq_t;

  typedef struct {
    rudp_rx_pkg::pkt_kind_t kind;
    seq_t                   stream;
    seq_t                   seq;
    seq_t                   acknum;
    logic [LEN_WIDTH-1:0]   dgram_len;
    logic [LEN_WIDTH-1:0]   pay_len;
    logic [TAG_WIDTH-1:0]   tag;
  } dgram_hdr_t;

  typedef struct {
    rudp_rx_pkg::res_kind_t kind;
    seq_t                   seq;
    seq_t                   acknum;
    logic [TAG_WIDTH-1:0]   tag;
    logic                   last;
  } rx_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  seq_t cfg_wdata;

  rudp_rx_in_if  in_ch ();
  rudp_rx_out_if out_ch ();

  reliable_udp_receive_reorder_top #(
    .WINDOW    (WINDOW),
    .HDR_SIZE  (HDR_SIZE),
    .MAX_DGRAM (MAX_DGRAM)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Headers waiting for the driver, and results the block still owes.
  dgram_hdr_t header_q[$];
  rx_result_t awaited_results[$];
  dgram_hdr_t offered_hdr;

  // Predictor state: a private copy of the stream register and reorder store.
  seq_t                 pred_own_stream = '0;
  seq_t                 pred_expected   = '0;
  logic [WINDOW-1:0]    pred_held       = '0;
  logic [TAG_WIDTH-1:0] pred_tag [WINDOW];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int src_gap        = 0;
  int snk_gap        = 0;
  // Quiet flags switch off random idling on one side for a whole phase.
  bit src_quiet      = 1'b0;
  bit snk_quiet      = 1'b0;
  // The long receiver hold-off is requested by the stimulus process and timed
  // by a process of its own.
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Mostly back to back, sometimes a short gap, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic rx_result_t result_of(rudp_rx_pkg::res_kind_t kind, seq_t seq,
                                           seq_t acknum, logic [TAG_WIDTH-1:0] tag);
    rx_result_t r;
    r.kind   = kind;
    r.seq    = seq;
    r.acknum = acknum;
    r.tag    = tag;
    r.last   = 1'b0;
    return r;
  endfunction

  // Works out every result one accepted header causes and updates the
  // predicted reorder store. Data is acked before any release, and the
  // release walks forward from the expected number while slots are held.
  function automatic void reorder_predict(dgram_hdr_t h);
    rx_result_t  step_res[$];
    int unsigned dlen;
    int unsigned plen;
    int unsigned slot;
    dlen = h.dgram_len;
    plen = h.pay_len;
    if (dlen < HDR_SIZE || dlen > MAX_DGRAM || dlen != plen + HDR_SIZE) return;
    if (h.kind == rudp_rx_pkg::PK_RDV) begin
      step_res.insert(0, result_of(rudp_rx_pkg::RES_RDV_SEEN, '0, '0, '0));
    end else if (h.stream != pred_own_stream) begin
      return;
    end else begin
      case (h.kind)
        rudp_rx_pkg::PK_SYN:
          step_res.insert(0, result_of(rudp_rx_pkg::RES_SYNACK_REPLY, '0, '0, '0));
        rudp_rx_pkg::PK_SYNACK:
          step_res.insert(0, result_of(rudp_rx_pkg::RES_SYNACK_SEEN, '0, '0, '0));
        rudp_rx_pkg::PK_NAT:
          step_res.insert(0, result_of(rudp_rx_pkg::RES_NAT_REPLY, '0, '0, '0));
        rudp_rx_pkg::PK_ACK:
          step_res.insert(0, result_of(rudp_rx_pkg::RES_ACK_RCVD, '0, h.acknum, '0));
        rudp_rx_pkg::PK_DATA: begin
          // Data at or past the far end of the window is dropped unacked.
          if (h.seq >= pred_expected && h.seq - pred_expected >= WINDOW) return;
          step_res.insert(0, result_of(rudp_rx_pkg::RES_ACK_REPLY, h.seq, '0, '0));
          if (h.seq >= pred_expected) begin
            slot = h.seq % WINDOW;
            if (!pred_held[slot]) begin
              pred_held[slot] = 1'b1;
              pred_tag[slot]  = h.tag;
              for (int i = 0; i < WINDOW; i++) begin
                slot = pred_expected % WINDOW;
                if (!pred_held[slot]) break;
                step_res.insert(step_res.size(),
                                result_of(rudp_rx_pkg::RES_DELIVER, pred_expected, '0,
                                          pred_tag[slot]));
                pred_held[slot] = 1'b0;
                pred_expected   = pred_expected + 1'b1;
              end
            end
          end
        end
        default: return;
      endcase
    end
    step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) awaited_results.insert(awaited_results.size(), step_res[i]);
  endfunction

  task automatic queue_hdr(rudp_rx_pkg::pkt_kind_t kind, seq_t stream, seq_t seq,
                           seq_t acknum, int unsigned dlen, int unsigned plen,
                           logic [TAG_WIDTH-1:0] tag);
    dgram_hdr_t h;
    h.kind      = kind;
    h.stream    = stream;
    h.seq       = seq;
    h.acknum    = acknum;
    h.dgram_len = LEN_WIDTH'(dlen);
    h.pay_len   = LEN_WIDTH'(plen);
    h.tag       = tag;
    header_q.insert(header_q.size(), h);
  endtask

  // Payload lengths are mostly short, with an occasional one up to the limit.
  function automatic int unsigned rand_plen();
    if ($urandom_range(0, 6) == 0) return $urandom_range(0, MAX_DGRAM - HDR_SIZE);
    return $urandom_range(0, 200);
  endfunction

  task automatic shuffle_seqs(ref seq_t seqs[$]);
    seq_t tmp;
    int   j;
    for (int i = seqs.size() - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = seqs[i];
      seqs[i] = seqs[j];
      seqs[j] = tmp;
    end
  endtask

  // Mostly complete runs of in-window data in shuffled order with random tags,
  // so the reorder store fills and drains, mixed with duplicates, control
  // traffic, foreign streams, bad lengths, unused kinds and out-of-window data.
  task automatic add_random_traffic(int n_items);
    seq_t        base;
    seq_t        blk_seqs[$];
    seq_t        foreign;
    int          added;
    int          blk;
    int unsigned plen;
    int unsigned dlen;
    base  = pred_expected;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(0, 99) < 70) begin
        blk = ($urandom_range(0, 9) == 0) ? $urandom_range(9, WINDOW) : $urandom_range(1, 8);
        blk_seqs.delete();
        for (int i = 0; i < blk; i++) blk_seqs.insert(blk_seqs.size(), base + i);
        shuffle_seqs(blk_seqs);
        foreach (blk_seqs[i]) begin
          plen = rand_plen();
          queue_hdr(rudp_rx_pkg::PK_DATA, pred_own_stream, blk_seqs[i], $urandom,
                    plen + HDR_SIZE, plen, $urandom_range(0, (1 << TAG_WIDTH) - 1));
          if ($urandom_range(0, 9) == 0) begin
            // Resend of a number from this run: still held or already released.
            queue_hdr(rudp_rx_pkg::PK_DATA, pred_own_stream,
                      blk_seqs[$urandom_range(0, i)], $urandom,
                      HDR_SIZE, 0, $urandom_range(0, (1 << TAG_WIDTH) - 1));
            added++;
          end
        end
        base  += blk;
        added += blk;
      end else begin
        plen = rand_plen();
        case ($urandom_range(0, 7))
          0: queue_hdr(rudp_rx_pkg::pkt_kind_t'($urandom_range(rudp_rx_pkg::PK_ACK,
                                                               rudp_rx_pkg::PK_RDV)),
                       pred_own_stream, $urandom, $urandom, plen + HDR_SIZE, plen,
                       $urandom_range(0, 65535));
          1: begin
            foreign = $urandom;
            if (foreign == '0) foreign = 1;
            queue_hdr(rudp_rx_pkg::pkt_kind_t'($urandom_range(rudp_rx_pkg::PK_DATA,
                                                               KIND_UNUSED_HI)),
                      pred_own_stream ^ foreign, base, $urandom, plen + HDR_SIZE, plen,
                      $urandom_range(0, 65535));
          end
          2: queue_hdr(rudp_rx_pkg::pkt_kind_t'($urandom_range(rudp_rx_pkg::PK_DATA,
                                                               rudp_rx_pkg::PK_RDV)),
                       pred_own_stream, base, $urandom, $urandom_range(0, HDR_SIZE - 1),
                       $urandom_range(0, LEN_ALL_ONES), $urandom_range(0, 65535));
          3: begin
            dlen = $urandom_range(MAX_DGRAM + 1, LEN_ALL_ONES);
            queue_hdr(rudp_rx_pkg::pkt_kind_t'($urandom_range(rudp_rx_pkg::PK_DATA,
                                                               rudp_rx_pkg::PK_RDV)),
                      pred_own_stream, base, $urandom, dlen, dlen - HDR_SIZE,
                      $urandom_range(0, 65535));
          end
          4: queue_hdr(rudp_rx_pkg::pkt_kind_t'($urandom_range(rudp_rx_pkg::PK_DATA,
                                                               rudp_rx_pkg::PK_RDV)),
                       pred_own_stream, base, $urandom, $urandom_range(HDR_SIZE, MAX_DGRAM),
                       $urandom_range(0, LEN_ALL_ONES), $urandom_range(0, 65535));
          5: queue_hdr(rudp_rx_pkg::pkt_kind_t'($urandom_range(KIND_UNUSED_LO,
                                                               KIND_UNUSED_HI)),
                       pred_own_stream, base, $urandom, plen + HDR_SIZE, plen,
                       $urandom_range(0, 65535));
          6: queue_hdr(rudp_rx_pkg::PK_DATA, pred_own_stream,
                       ($urandom_range(0, 1) == 0) ? base + WINDOW + $urandom_range(0, 40)
                                                   : seq_t'($urandom),
                       $urandom, plen + HDR_SIZE, plen, $urandom_range(0, 65535));
          default: queue_hdr(rudp_rx_pkg::PK_DATA, pred_own_stream,
                             (base == '0) ? seq_t'($urandom) : base - $urandom_range(1, base),
                             $urandom, plen + HDR_SIZE, plen, $urandom_range(0, 65535));
        endcase
        added++;
      end
    end
  endtask

  // Everything offered, taken and checked, then a short drain. Sampled on the
  // falling edge so the clocked processes have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (header_q.size() != 0 || in_ch.valid || awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_own_stream(seq_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we          <= 1'b0;
    pred_own_stream  = value;
    @(negedge clk);
  endtask

  // Source side: one header per transaction, valid held until taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap     <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) reorder_predict(offered_hdr);
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap != 0) begin
          in_ch.valid <= 1'b0;
          src_gap     <= src_gap - 1;
        end else if (header_q.size() != 0) begin
          offered_hdr        <= header_q[0];
          in_ch.valid        <= 1'b1;
          in_ch.pkt_kind     <= header_q[0].kind;
          in_ch.pkt_stream   <= header_q[0].stream;
          in_ch.pkt_seq      <= header_q[0].seq;
          in_ch.pkt_acknum   <= header_q[0].acknum;
          in_ch.datagram_len <= header_q[0].dgram_len;
          in_ch.payload_len  <= header_q[0].pay_len;
          in_ch.payload_tag  <= header_q[0].tag;
          void'(header_q.pop_front());
          src_gap <= src_quiet ? 0 : pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Times the long receiver hold-off so the block fills and stalls its input.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_requests;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Sink side: checks each result transaction, then decides on backpressure.
  always @(posedge clk) begin : check_results
    rx_result_t got;
    rx_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_gap      <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind   = rudp_rx_pkg::res_kind_t'(out_ch.result_kind);
        got.seq    = out_ch.out_seq;
        got.acknum = out_ch.out_acknum;
        got.tag    = out_ch.out_tag;
        got.last   = out_ch.last;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result kind %0d seq %0d with nothing expected",
                                    got.kind, got.seq));
        end else begin
          want = awaited_results.pop_front();
          if (got.kind !== want.kind)
            report_mismatch($sformatf("result_kind %0d, expected %0d (seq %0d)",
                                      got.kind, want.kind, want.seq));
          if (got.seq !== want.seq)
            report_mismatch($sformatf("out_seq %0d, expected %0d", got.seq, want.seq));
          if (got.acknum !== want.acknum)
            report_mismatch($sformatf("out_acknum %0h, expected %0h (seq %0d)",
                                      got.acknum, want.acknum, want.seq));
          if (got.tag !== want.tag)
            report_mismatch($sformatf("out_tag %0h, expected %0h (seq %0d)",
                                      got.tag, want.tag, want.seq));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b (seq %0d)",
                                      got.last, want.last, want.seq));
        end
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (snk_gap != 0) begin
        out_ch.ready <= 1'b0;
        snk_gap      <= snk_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        snk_gap      <= (snk_quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      end
    end
  end

  // Guards against a hang anywhere in the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    seq_t window_seqs[$];
    seq_t base;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed checks with the stream register still at its reset value.
    // Length limits first: too short, too long and disagreeing lengths.
    queue_hdr(rudp_rx_pkg::PK_DATA, '0, '0, '0, 0, 0, '0);
    queue_hdr(rudp_rx_pkg::PK_SYN, '0, '0, '0, HDR_SIZE - 1, LEN_ALL_ONES, '0);
    queue_hdr(rudp_rx_pkg::PK_SYN, '0, '0, '0, LEN_ALL_ONES, LEN_ALL_ONES - HDR_SIZE, '0);
    queue_hdr(rudp_rx_pkg::PK_NAT, '0, '0, '0, MAX_DGRAM + 1, MAX_DGRAM + 1 - HDR_SIZE, '0);
    queue_hdr(rudp_rx_pkg::PK_NAT, '0, '0, '0, 100, 50, '0);
    // SYN, SYNACK, NAT and ACK at legal lengths, SYN at the longest and SYNACK and an ACK at the shortest.
    queue_hdr(rudp_rx_pkg::PK_SYN, '0, '0, '0, MAX_DGRAM, MAX_DGRAM - HDR_SIZE, '0);
    queue_hdr(rudp_rx_pkg::PK_SYNACK, '0, '0, '0, HDR_SIZE, 0, '0);
    queue_hdr(rudp_rx_pkg::PK_NAT, '0, '0, '0, HDR_SIZE + 8, 8, '0);
    queue_hdr(rudp_rx_pkg::PK_ACK, '0, '0, '1, HDR_SIZE + 4, 4, '0);
    queue_hdr(rudp_rx_pkg::PK_ACK, '0, '1, '0, HDR_SIZE, 0, '1);
    // A rendezvous is seen from any stream; anything else foreign is dropped, as are the unused kinds.
    queue_hdr(rudp_rx_pkg::PK_RDV, '1, '1, '1, HDR_SIZE, 0, '1);
    queue_hdr(rudp_rx_pkg::PK_SYN, '1, '0, '0, HDR_SIZE, 0, '0);
    queue_hdr(rudp_rx_pkg::pkt_kind_t'(KIND_UNUSED_LO), '0, '0, '0, HDR_SIZE, 0, '0);
    queue_hdr(rudp_rx_pkg::pkt_kind_t'(KIND_UNUSED_HI), '0, '0, '0, HDR_SIZE, 0, '0);
    // Reordering: a gap held, a resend of a held number, the gap filled so
    // both release, an old resend, the top of the window, one past it, the
    // largest sequence number, and the next expected number.
    queue_hdr(rudp_rx_pkg::PK_DATA, '0, 1, '0, HDR_SIZE + 64, 64, '1);
    queue_hdr(rudp_rx_pkg::PK_DATA, '0, 1, '0, HDR_SIZE + 64, 64, 16'h1234);
    queue_hdr(rudp_rx_pkg::PK_DATA, '0, 0, '0, MAX_DGRAM, MAX_DGRAM - HDR_SIZE, '0);
    queue_hdr(rudp_rx_pkg::PK_DATA, '0, 0, '0, HDR_SIZE, 0, 16'h0F0F);
    queue_hdr(rudp_rx_pkg::PK_DATA, '0, 2 + WINDOW - 1, '0, HDR_SIZE + 1, 1, 16'hA5A5);
    queue_hdr(rudp_rx_pkg::PK_DATA, '0, 2 + WINDOW, '0, HDR_SIZE + 1, 1, 16'hC3C3);
    queue_hdr(rudp_rx_pkg::PK_DATA, '0, '1, '1, HDR_SIZE + 2, 2, 16'h3C3C);
    queue_hdr(rudp_rx_pkg::PK_DATA, '0, 2, '0, HDR_SIZE + 3, 3, 16'h5A5A);
    wait_idle();

    write_own_stream($urandom);
    add_random_traffic(25);
    wait_idle();

    // Pressure: the receiver stops for a long stretch while the sender keeps
    // offering a full window out of order. The final header fills the first
    // slot and releases the whole window in one go.
    write_own_stream('1);
    src_quiet = 1'b1;
    hold_requests++;
    base = pred_expected;
    for (int i = 1; i < WINDOW; i++) window_seqs.insert(window_seqs.size(), base + i);
    shuffle_seqs(window_seqs);
    foreach (window_seqs[i])
      queue_hdr(rudp_rx_pkg::PK_DATA, '1, window_seqs[i], '0, HDR_SIZE + 8, 8,
                $urandom_range(0, (1 << TAG_WIDTH) - 1));
    queue_hdr(rudp_rx_pkg::PK_DATA, '1, base, '0, HDR_SIZE + 8, 8,
              $urandom_range(0, (1 << TAG_WIDTH) - 1));
    queue_hdr(rudp_rx_pkg::PK_SYN, '1, '0, '0, HDR_SIZE, 0, '0);
    queue_hdr(rudp_rx_pkg::PK_ACK, '1, '0, $urandom, HDR_SIZE, 0, '0);
    queue_hdr(rudp_rx_pkg::PK_NAT, '1, '0, '0, HDR_SIZE, 0, '0);
    wait_idle();
    src_quiet = 1'b0;

    // A stretch with no idling on either side.
    write_own_stream('0);
    src_quiet = 1'b1;
    snk_quiet = 1'b1;
    add_random_traffic(12);
    wait_idle();
    src_quiet = 1'b0;
    snk_quiet = 1'b0;

    write_own_stream($urandom);
    add_random_traffic(10);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
